[rtl/frfa_pkg.sv]
// Package: constants, types and controller-datapath signal groups for the allocator.
package frfa_pkg;

  localparam int MaxRegions = 16;
  localparam int HeapWords  = 1024;
  localparam int IdxW       = 4;
  localparam int CntW       = 5;
  localparam int StartW     = 10;
  localparam int LenW       = 11;

  localparam logic [LenW-1:0] HeapLen = LenW'((HeapWords > 2047) ? 2047 : HeapWords);

  localparam logic [1:0] StOk       = 2'd0;
  localparam logic [1:0] StNoFit    = 2'd1;
  localparam logic [1:0] StFull     = 2'd2;
  localparam logic [1:0] StZeroLen  = 2'd3;

  localparam logic [1:0] PolBest  = 2'd0;
  localparam logic [1:0] PolWorst = 2'd1;
  localparam logic [1:0] PolFirst = 2'd2;
  localparam logic [1:0] PolNext  = 2'd3;

  localparam logic ActAlloc  = 1'b0;
  localparam logic ActInsert = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_DECIDE, S_UPDATE, S_SHIFT, S_DONE
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;      // capture the request
    logic scan_clr;  // reset the scan walker
    logic scan_step; // examine one entry
    logic do_insert;
    logic do_alloc;  // shrink the chosen entry
    logic shift_step;
    logic shift_end;
    logic [1:0] res_status;
    logic res_ok;
    logic res_valid;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic zero_len;
    logic is_insert;
    logic full;
    logic scan_last;
    logic found;
    logic becomes_empty;
    logic shift_last;
  } dp_stat_t;

endpackage

[rtl/frfa_ctrl.sv]
// Controller state machine sequencing scan, update and compaction for each request.
module frfa_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  frfa_pkg::dp_stat_t stat,
  output frfa_pkg::dp_cmd_t  cmd,
  output logic              busy
);
  import frfa_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:   if (start) state_next = S_DECIDE;
      S_DECIDE: begin
        if (stat.zero_len || stat.is_insert) state_next = S_DONE;
        else state_next = S_SCAN;
      end
      S_SCAN:   if (stat.scan_last) state_next = S_UPDATE;
      S_UPDATE: begin
        if (stat.found && stat.becomes_empty) state_next = S_SHIFT;
        else state_next = S_IDLE;
      end
      S_SHIFT:  if (stat.shift_last) state_next = S_IDLE;
      S_DONE:   state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    busy = (state != S_IDLE);
    case (state)
      S_IDLE: begin
        cmd.load = start;
      end
      S_DECIDE: begin
        cmd.scan_clr = 1'b1;
        if (stat.zero_len) begin
          cmd.res_status = StZeroLen;
          cmd.res_valid = 1'b1;
        end else if (stat.is_insert) begin
          cmd.res_status = stat.full ? StFull : StOk;
          cmd.do_insert = !stat.full;
          cmd.res_valid = 1'b1;
        end
      end
      S_SCAN: cmd.scan_step = 1'b1;
      S_UPDATE: begin
        cmd.res_valid = 1'b1;
        if (stat.found) begin
          cmd.do_alloc = 1'b1;
          cmd.res_ok = 1'b1;
          cmd.res_status = StOk;
        end else begin
          cmd.res_status = StNoFit;
        end
      end
      S_SHIFT: begin
        cmd.shift_step = 1'b1;
        cmd.shift_end = stat.shift_last;
      end
      default: ;
    endcase
  end

endmodule

[rtl/frfa_dp.sv]
// Datapath: region table, scan comparator, rover and result registers.
module frfa_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  frfa_pkg::dp_cmd_t             cmd,
  input  logic [1:0]                    fit_policy,
  input  logic                          action,
  input  logic [frfa_pkg::StartW-1:0]   region_start,
  input  logic [frfa_pkg::LenW-1:0]     length,
  output frfa_pkg::dp_stat_t            stat,
  output logic                          done,
  output logic [1:0]                    status,
  output logic [frfa_pkg::StartW-1:0]   block_start,
  output logic [frfa_pkg::CntW-1:0]     regions_used
);
  import frfa_pkg::*;

  logic [StartW-1:0] tbl_start [MaxRegions];
  logic [LenW-1:0]   tbl_len   [MaxRegions];
  logic [CntW-1:0]   count;
  logic [IdxW-1:0]   rover;
  logic              req_act;
  logic [StartW-1:0] req_start;
  logic [LenW-1:0]   req_len;
  logic [1:0]        pol;
  logic [CntW-1:0]   steps;   // entries examined so far
  logic [IdxW-1:0]   pos;     // entry under examination
  logic              found;
  logic [IdxW-1:0]   best;
  logic [IdxW-1:0]   shp;     // compaction pointer
  logic              fits, better;
  logic [LenW-1:0]   cur_len, best_len;
  logic [CntW-1:0]   rover_ext, pos_inc;

  assign cur_len   = tbl_len[pos];
  assign best_len  = tbl_len[best];
  assign fits      = (cur_len >= req_len) && (steps < count);
  assign rover_ext = {1'b0, rover};
  assign pos_inc   = {1'b0, pos} + CntW'(1);

  always_comb begin
    better = 1'b0;
    if (!found) better = 1'b1;
    else begin
      case (pol)
        PolBest:  better = cur_len < best_len;
        PolWorst: better = cur_len > best_len;
        PolFirst: better = tbl_start[pos] < tbl_start[best];
        default:  better = 1'b0;
      endcase
    end
  end

  always_comb begin
    stat.zero_len      = (req_len == '0);
    stat.is_insert     = (req_act == ActInsert);
    stat.full          = (count >= CntW'(MaxRegions));
    stat.scan_last     = (steps + CntW'(1) >= count) || (found && pol == PolNext);
    stat.found         = found;
    stat.becomes_empty = (best_len == req_len);
    stat.shift_last    = ({1'b0, shp} + CntW'(1) >= count);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_act   <= action;
      req_start <= region_start;
      req_len   <= length;
      pol       <= fit_policy;
    end
    if (cmd.scan_clr) begin
      steps <= '0;
      found <= 1'b0;
      pos   <= (pol == PolNext && rover_ext < count) ? rover : '0;
    end
    if (cmd.scan_step) begin
      steps <= steps + CntW'(1);
      if (fits && better && !(pol == PolNext && found)) begin
        found <= 1'b1;
        best  <= pos;
      end
      pos <= (pos_inc >= count) ? '0 : pos_inc[IdxW-1:0];
    end
    if (cmd.do_insert) begin
      tbl_start[count[IdxW-1:0]] <= req_start;
      tbl_len[count[IdxW-1:0]]   <= req_len;
    end
    if (cmd.do_alloc) begin
      tbl_len[best]   <= best_len - req_len;
      tbl_start[best] <= tbl_start[best] + req_len[StartW-1:0];
      shp <= best;
    end
    // The count has already dropped by one here, so entries up to the new count move up.
    if (cmd.shift_step && ({1'b0, shp} < count)) begin
      tbl_start[shp] <= tbl_start[shp + IdxW'(1)];
      tbl_len[shp]   <= tbl_len[shp + IdxW'(1)];
      shp <= shp + IdxW'(1);
    end
    if (cmd.res_valid) begin
      status      <= cmd.res_status;
      block_start <= cmd.res_ok ? tbl_start[best] : '0;
    end
    if (rst) begin
      tbl_start[0] <= '0;
      tbl_len[0]   <= HeapLen;
    end
  end

  // Control registers; the count after a removal is reported at shift end.
  logic [CntW-1:0] cnt_dec;
  logic [IdxW-1:0] rov_dec;
  logic            empty_hit;
  assign empty_hit = cmd.do_alloc && stat.becomes_empty;
  assign cnt_dec   = count - CntW'(1);
  always_comb begin
    rov_dec = (pol == PolNext) ? best : rover;
    if (rov_dec > best) rov_dec = rov_dec - IdxW'(1);
    if ({1'b0, rov_dec} >= cnt_dec) rov_dec = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= CntW'(1);
      rover <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cmd.do_insert) count <= count + CntW'(1);
      if (cmd.res_valid) begin
        regions_used <= cmd.do_insert ? count + CntW'(1) : (empty_hit ? cnt_dec : count);
      end
      if (cmd.res_valid && !empty_hit) done <= 1'b1;
      if (cmd.do_alloc) begin
        if (empty_hit) begin
          count <= cnt_dec;
          rover <= rov_dec;
        end else if (pol == PolNext) begin
          rover <= best;
        end
      end
      if (cmd.shift_end) done <= 1'b1;
    end
  end

endmodule

[rtl/free_region_fit_allocator.sv]
// Top level of the free-region fit allocator.
//   channel  | signals                                   | direction
//   request  | start, busy, action, region_start, length | in (busy out)
//   result   | done, status, block_start, regions_used   | out
//   config   | cfg_valid, cfg_ready, cfg_data            | in (cfg_ready out)
// An insert or zero-length request keeps busy high through the decide and done states,
// with the result in done. An allocation keeps busy through decide, scan (at least one
// entry) and update; when the chosen region empties, the shift state compacts the table
// by moving the later entries down. The result follows as busy falls.
// Reset is synchronous; the table then holds one region covering the heap.
// The result strobe done lasts one cycle and cannot be stalled.
module free_region_fit_allocator (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic                        action,
  input  logic [frfa_pkg::StartW-1:0] region_start,
  input  logic [frfa_pkg::LenW-1:0]   length,
  output logic                        done,
  output logic [1:0]                  status,
  output logic [frfa_pkg::StartW-1:0] block_start,
  output logic [frfa_pkg::CntW-1:0]   regions_used,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [1:0]                  cfg_data
);
  import frfa_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic [1:0] fit_policy;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) fit_policy <= PolBest;
    else if (cfg_valid && cfg_ready) fit_policy <= cfg_data;
  end

  frfa_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .stat(stat), .cmd(cmd), .busy(busy)
  );

  frfa_dp u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .fit_policy(fit_policy),
    .action(action), .region_start(region_start), .length(length),
    .stat(stat), .done(done), .status(status), .block_start(block_start),
    .regions_used(regions_used)
  );

endmodule

[rtl/frfa_checker.sv]
// Port-level checker for the allocator, bound to the top level.
module frfa_checker (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic       done,
  input logic [1:0] status,
  input logic [9:0] block_start,
  input logic [4:0] regions_used
);
  import frfa_pkg::*;

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy) else $error("accepted request did not raise busy");
  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("result strobe longer than one cycle");
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy)) else $error("result without a request in progress");
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    done && status != StOk |-> block_start == '0) else $error("block start on failure");
  a_used_range: assert property (@(posedge clk) disable iff (rst)
    done |-> regions_used <= 5'(MaxRegions)) else $error("region count out of range");

endmodule

bind free_region_fit_allocator frfa_checker u_frfa_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done),
  .status(status), .block_start(block_start), .regions_used(regions_used)
);

[tb/free_region_fit_allocator_tb.sv]
// Self-checking testbench for the free-region fit allocator, with a predictor and random requests.
module free_region_fit_allocator_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import frfa_pkg::*;

  typedef struct packed {
    logic             act;
    logic [StartW-1:0] rstart;
    logic [LenW-1:0]   len;
  } request_t;

  typedef struct packed {
    logic [1:0]        st;
    logic [StartW-1:0] blk;
    logic [CntW-1:0]   used;
  } answer_t;

  localparam int CycleLimit = 600000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic action = 1'b0;
  logic [StartW-1:0] region_start = '0;
  logic [LenW-1:0] length = '0;
  logic cfg_valid = 1'b0;
  logic [1:0] cfg_data = '0;
  logic busy, done, cfg_ready;
  logic [1:0] status;
  logic [StartW-1:0] block_start;
  logic [CntW-1:0] regions_used;

  request_t pending_requests[$];
  answer_t  awaited_answers[$];
  int errors = 0;
  int cycles = 0;
  int requests_sent = 0;
  int answers_seen = 0;
  int gap_left = 0;
  bit quiet = 1'b0;
  bit hold_requests = 1'b0;

  // Shadow copy of the allocator state.
  logic [StartW-1:0] tab_start[MaxRegions];
  logic [LenW-1:0]   tab_len[MaxRegions];
  int tab_count;
  int rover;
  logic [1:0] policy;

  always #5 clk = ~clk;

  free_region_fit_allocator u_dut (
    .clk, .rst, .start, .busy, .action, .region_start, .length,
    .done, .status, .block_start, .regions_used,
    .cfg_valid, .cfg_ready, .cfg_data
  );

  function automatic answer_t predict_allocation(request_t r);
    answer_t a;
    int pick;
    int k;
    int first;
    a = '0;
    pick = -1;
    if (r.len == 0) begin
      a.st = StZeroLen;
    end else if (r.act == ActInsert) begin
      if (tab_count >= MaxRegions) begin
        a.st = StFull;
      end else begin
        tab_start[tab_count] = r.rstart;
        tab_len[tab_count] = r.len;
        tab_count++;
      end
    end else begin
      if (policy == PolNext) begin
        first = (rover < tab_count) ? rover : 0;
        for (int i = 0; i < tab_count; i++) begin
          k = (first + i) % tab_count;
          if (pick < 0 && tab_len[k] >= r.len) pick = k;
        end
      end else begin
        for (int i = 0; i < tab_count; i++) begin
          if (tab_len[i] >= r.len) begin
            if (pick < 0) pick = i;
            else if (policy == PolBest && tab_len[i] < tab_len[pick]) pick = i;
            else if (policy == PolWorst && tab_len[i] > tab_len[pick]) pick = i;
            else if (policy == PolFirst && tab_start[i] < tab_start[pick]) pick = i;
          end
        end
      end
      if (pick < 0) begin
        a.st = StNoFit;
      end else begin
        a.blk = tab_start[pick];
        tab_len[pick] = tab_len[pick] - r.len;
        tab_start[pick] = tab_start[pick] + r.len[StartW-1:0];
        if (policy == PolNext) rover = pick;
        if (tab_len[pick] == 0) begin
          for (int i = pick; i + 1 < tab_count; i++) begin
            tab_start[i] = tab_start[i + 1];
            tab_len[i] = tab_len[i + 1];
          end
          tab_count--;
          if (rover > pick) rover--;
          if (rover >= tab_count) rover = 0;
        end
      end
    end
    a.used = CntW'(tab_count);
    return a;
  endfunction

  // Request driver: takes items from the pending queue with random bursts of idling.
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (start && busy) begin
      // Request still waiting to be taken.
    end else begin
      if (start) begin
        awaited_answers.push_back(predict_allocation({action, region_start, length}));
        requests_sent++;
      end
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        start <= 1'b0;
      end else if (!quiet && start && $urandom_range(0, 9) == 0) begin
        gap_left <= $urandom_range(0, 5);
        start <= 1'b0;
      end else if (pending_requests.size() > 0 && !hold_requests) begin
        request_t r;
        r = pending_requests.pop_front();
        start <= 1'b1;
        action <= r.act;
        region_start <= r.rstart;
        length <= r.len;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Result monitor.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst && done) begin
      answers_seen++;
      if (awaited_answers.size() == 0) begin
        $display("%0t: unexpected result status=%0d start=%0d used=%0d", $time,
                 status, block_start, regions_used);
        errors++;
      end else begin
        answer_t e;
        e = awaited_answers.pop_front();
        if (e.st !== status || e.blk !== block_start || e.used !== regions_used) begin
          $display("%0t: mismatch expected status=%0d start=%0d used=%0d, actual %0d %0d %0d",
                   $time, e.st, e.blk, e.used, status, block_start, regions_used);
          errors++;
        end
      end
    end
    if (cycles > CycleLimit) begin
      $display("Timeout after %0d cycles", cycles);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic request_t random_request();
    request_t r;
    int pick;
    r.act = $urandom_range(0, 99) < 35 ? ActInsert : ActAlloc;
    r.rstart = StartW'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 5) r.len = '0;
    else if (pick < 70) r.len = LenW'($urandom_range(1, 64));
    else if (pick < 92) r.len = LenW'($urandom_range(1, 400));
    else r.len = LenW'($urandom_range(0, 2047));
    return r;
  endfunction

  task automatic wait_drained();
    while (pending_requests.size() > 0 || start || awaited_answers.size() > 0)
      @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_policy(logic [1:0] p);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= p;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    policy = p;
  endtask

  initial begin
    logic [1:0] order[6];
    policy = PolBest;
    tab_count = 1;
    rover = 0;
    tab_start[0] = '0;
    tab_len[0] = HeapLen;
    order = '{PolBest, PolWorst, PolFirst, PolNext, PolFirst, PolWorst};
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed: zero length, exact allocation of whole heap, empty table, fill to full.
    pending_requests.push_back({ActAlloc, 10'd5, 11'd0});
    pending_requests.push_back({ActInsert, 10'd7, 11'd0});
    pending_requests.push_back({ActAlloc, 10'd0, 11'd2047});
    pending_requests.push_back({ActAlloc, 10'd0, 11'd1024});
    pending_requests.push_back({ActAlloc, 10'd0, 11'd1});
    for (int i = 0; i < 17; i++)
      pending_requests.push_back({ActInsert, 10'(i * 61 + 1000), 11'(i * 37 + 3)});
    pending_requests.push_back({ActAlloc, 10'h3FF, 11'd600});
    pending_requests.push_back({ActAlloc, 10'd0, 11'd3});
    wait_drained();

    for (int ph = 0; ph < 6; ph++) begin
      write_policy(order[ph]);
      if (ph == 3) begin
        // Part way through a burst, hold off until every result is in, then carry on.
        for (int i = 0; i < 30; i++) pending_requests.push_back(random_request());
        repeat (60) @(posedge clk);
        hold_requests = 1'b1;
        while (start || awaited_answers.size() > 0) @(posedge clk);
        hold_requests = 1'b0;
      end
      if (ph == 5) quiet = 1'b1;
      for (int i = 0; i < 300; i++) pending_requests.push_back(random_request());
      wait_drained();
    end

    $display("Ran %0d requests over all four fit policies, %0d results checked.",
             requests_sent, answers_seen);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
